// File: design/wls_pkg.sv
package wls_pkg;

    // Fixed field widths of the item and result channels
    localparam int ACTION_W = 3;
    localparam int KEY_W    = 16;
    localparam int WEIGHT_W = 16;
    localparam int RANDOM_W = 16;
    localparam int STATUS_W = 2;

    // Defaults for the top-level parameters
    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_KEY_BITS    = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PICK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE      = 2'd3;

    // Draw is the scaled random value plus this offset, so it lies in 1..total
    localparam int DRAW_OFFSET = 1;

    typedef struct packed {
        logic [ACTION_W-1:0]        action;
        logic [KEY_W-1:0]           move_key;
        logic signed [WEIGHT_W-1:0] weight;
        logic [RANDOM_W-1:0]        random_word;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    picked_key;
        logic                picked_valid;
    } t_result;

endpackage

// File: design/wls_ifs.sv
interface wls_item_if;
    logic                                        valid;
    logic                                        ready;
    logic [wls_pkg::ACTION_W-1:0]                action;
    logic [wls_pkg::KEY_W-1:0]                   move_key;
    logic signed [wls_pkg::WEIGHT_W-1:0]         weight;
    logic [wls_pkg::RANDOM_W-1:0]                random_word;

    modport source (output valid, output action, output move_key, output weight,
                    output random_word, input ready);
    modport sink   (input valid, input action, input move_key, input weight,
                    input random_word, output ready);
endinterface

interface wls_result_if;
    logic                           valid;
    logic                           ready;
    logic [wls_pkg::STATUS_W-1:0]   status;
    logic [wls_pkg::KEY_W-1:0]      picked_key;
    logic                           picked_valid;

    modport source (output valid, output status, output picked_key, output picked_valid,
                    input ready);
    modport sink   (input valid, input status, input picked_key, input picked_valid,
                    output ready);
endinterface

// File: design/wls_draw.sv
module wls_draw #(
    parameter int TOTAL_BITS = 21
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wls_pkg::RANDOM_W-1:0]  i_random,
    input  logic [TOTAL_BITS-1:0]         i_total,
    output logic                          o_done,
    output logic [TOTAL_BITS-1:0]         o_draw
);
    import wls_pkg::*;

    localparam int LO_W   = TOTAL_BITS / 2;
    localparam int HI_W   = TOTAL_BITS - LO_W;
    localparam int LO_PW  = RANDOM_W + LO_W;
    localparam int HI_PW  = RANDOM_W + HI_W;
    localparam int PROD_W = RANDOM_W + TOTAL_BITS;

    logic                  r_v1;
    logic                  r_v2;
    logic [LO_PW-1:0]      r_lo;
    logic [HI_PW-1:0]      r_hi;
    logic [TOTAL_BITS-1:0] r_draw;
    logic [PROD_W-1:0]     w_prod;

    // two narrow partial products, then recombine
    assign w_prod = (PROD_W'(r_hi) << LO_W) + PROD_W'(r_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
        r_lo   <= LO_PW'(i_random) * LO_PW'(i_total[LO_W-1:0]);
        r_hi   <= HI_PW'(i_random) * HI_PW'(i_total[TOTAL_BITS-1:LO_W]);
        r_draw <= TOTAL_BITS'(w_prod[PROD_W-1:RANDOM_W]) + TOTAL_BITS'(DRAW_OFFSET);
    end

    assign o_done = r_v2;
    assign o_draw = r_draw;

endmodule

// File: design/wls_engine.sv
module wls_engine #(
    parameter int CAPACITY    = 64,
    parameter int KEY_BITS    = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  wls_pkg::t_request i_req,
    output logic              o_idle,
    output logic              o_done,
    output wls_pkg::t_result  o_res,
    input  logic              i_res_take
);
    import wls_pkg::*;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int TOT_W   = WEIGHT_BITS - 1 + $clog2(CAPACITY);
    localparam int WORD_W  = 1 + KEY_BITS + WEIGHT_BITS;
    localparam logic [ADDR_W-1:0] LAST = ADDR_W'(CAPACITY - 1);

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_SCAN, S_DRAW, S_WRITE, S_DONE
    } t_state;

    // table: {used, key, weight}
    logic [WORD_W-1:0] mem [CAPACITY];
    logic [WORD_W-1:0] r_rd_data;

    t_state               r_state, n_state;
    logic                 r_init, n_init;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic                 r_issue, n_issue;
    logic                 r_rd_valid;
    logic [ADDR_W-1:0]    r_rd_idx;
    logic [ACTION_W-1:0]  r_act, n_act;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [WEIGHT_BITS-1:0] r_wt, n_wt;
    logic [RANDOM_W-1:0]  r_rnd, n_rnd;
    logic                 r_pass2, n_pass2;
    logic                 r_hit, n_hit;
    logic [ADDR_W-1:0]    r_hit_idx, n_hit_idx;
    logic                 r_free, n_free;
    logic [ADDR_W-1:0]    r_free_idx, n_free_idx;
    logic [TOT_W-1:0]     r_total, n_total;
    logic [TOT_W-1:0]     r_run, n_run;
    logic [TOT_W-1:0]     r_draw, n_draw;
    logic                 r_draw_go, n_draw_go;
    t_result              r_res, n_res;

    logic                 w_wr_en;
    logic [ADDR_W-1:0]    w_wr_addr;
    logic [WORD_W-1:0]    w_wr_data;
    logic                 w_rd_en;

    logic                   d_used;
    logic [KEY_BITS-1:0]    d_key;
    logic [WEIGHT_BITS-1:0] d_wt;
    logic                   d_pos;
    logic [TOT_W-1:0]       d_add;
    logic [TOT_W-1:0]       d_run;

    logic                 w_draw_done;
    logic [TOT_W-1:0]     w_draw_val;

    wls_draw #(
        .TOTAL_BITS (TOT_W)
    ) u_draw (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_draw_go),
        .i_random (r_rnd),
        .i_total  (r_total),
        .o_done   (w_draw_done),
        .o_draw   (w_draw_val)
    );

    assign d_used = r_rd_data[WORD_W-1];
    assign d_key  = r_rd_data[WORD_W-2 -: KEY_BITS];
    assign d_wt   = r_rd_data[WEIGHT_BITS-1:0];
    assign d_pos  = d_used && !d_wt[WEIGHT_BITS-1] && (d_wt != '0);
    assign d_add  = TOT_W'(d_wt[WEIGHT_BITS-2:0]);
    assign d_run  = r_run + d_add;

    assign w_rd_en = r_issue;

    always_comb begin
        n_state    = r_state;
        n_init     = r_init;
        n_addr     = r_addr;
        n_issue    = r_issue;
        n_act      = r_act;
        n_key      = r_key;
        n_wt       = r_wt;
        n_rnd      = r_rnd;
        n_pass2    = r_pass2;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_total    = r_total;
        n_run      = r_run;
        n_draw     = r_draw;
        n_draw_go  = 1'b0;
        n_res      = r_res;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_addr;
        w_wr_data  = '0;

        case (r_state)
            S_SWEEP: begin
                w_wr_en = 1'b1;
                n_addr  = r_addr + 1'b1;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_act   = i_req.action;
                    n_key   = KEY_BITS'(i_req.move_key);
                    n_wt    = WEIGHT_BITS'(i_req.weight);
                    n_rnd   = i_req.random_word;
                    n_res   = '{status: ST_OK, picked_key: '0, picked_valid: 1'b0};
                    n_pass2 = 1'b0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_total = '0;
                    n_run   = '0;
                    n_addr  = '0;
                    case (i_req.action)
                        ACT_ADD, ACT_REMOVE, ACT_UPDATE: begin
                            n_issue = 1'b1;
                            n_state = S_SCAN;
                        end
                        ACT_PICK: begin
                            n_issue      = 1'b1;
                            n_res.status = ST_NONE;
                            n_state      = S_SCAN;
                        end
                        ACT_CLEAR: n_state = S_SWEEP;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_issue) begin
                    if (r_addr == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (r_rd_valid) begin
                    if (r_act == ACT_PICK) begin
                        if (!r_pass2) begin
                            if (d_pos) n_total = r_total + d_add;
                        end else if (d_pos && !r_hit) begin
                            n_run = d_run;
                            if (r_draw <= d_run) begin
                                n_hit              = 1'b1;
                                n_res.status       = ST_OK;
                                n_res.picked_key   = KEY_W'(d_key);
                                n_res.picked_valid = 1'b1;
                            end
                        end
                    end else begin
                        if (d_used && (d_key == r_key) && !r_hit) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_rd_idx;
                        end
                        if (!d_used && !r_free) begin
                            n_free     = 1'b1;
                            n_free_idx = r_rd_idx;
                        end
                    end
                    if (r_rd_idx == LAST) begin
                        if (r_act != ACT_PICK) begin
                            n_state = S_WRITE;
                        end else if (r_pass2 || n_total == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_draw_go = 1'b1;
                            n_state   = S_DRAW;
                        end
                    end
                end
            end
            S_DRAW: begin
                if (w_draw_done) begin
                    n_draw  = w_draw_val;
                    n_pass2 = 1'b1;
                    n_hit   = 1'b0;
                    n_run   = '0;
                    n_addr  = '0;
                    n_issue = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_WRITE: begin
                n_state = S_DONE;
                case (r_act)
                    ACT_ADD: begin
                        w_wr_data = {1'b1, r_key, r_wt};
                        if (r_hit) begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = r_hit_idx;
                        end else if (r_free) begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = r_free_idx;
                        end else begin
                            n_res.status = ST_FULL;
                        end
                    end
                    ACT_REMOVE: begin
                        w_wr_addr = r_hit_idx;
                        if (r_hit) w_wr_en = 1'b1;
                        else       n_res.status = ST_NOT_FOUND;
                    end
                    ACT_UPDATE: begin
                        w_wr_data = {1'b1, r_key, r_wt};
                        w_wr_addr = r_hit_idx;
                        if (r_hit) w_wr_en = 1'b1;
                        else       n_res.status = ST_NOT_FOUND;
                    end
                    default: ;
                endcase
            end
            S_DONE: begin
                if (i_res_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) mem[w_wr_addr] <= w_wr_data;
        if (w_rd_en) r_rd_data <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SWEEP;
            r_init     <= 1'b1;
            r_addr     <= '0;
            r_issue    <= 1'b0;
            r_rd_valid <= 1'b0;
            r_draw_go  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init     <= n_init;
            r_addr     <= n_addr;
            r_issue    <= n_issue;
            r_rd_valid <= r_issue;
            r_draw_go  <= n_draw_go;
        end
        r_rd_idx   <= r_addr;
        r_act      <= n_act;
        r_key      <= n_key;
        r_wt       <= n_wt;
        r_rnd      <= n_rnd;
        r_pass2    <= n_pass2;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_total    <= n_total;
        r_run      <= n_run;
        r_draw     <= n_draw;
        r_res      <= n_res;
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

    // read and write phases of an operation never overlap
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr_en && w_rd_en))
        else $error("table read and write in the same cycle");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!w_wr_en && !r_issue && !r_rd_valid))
        else $error("table access while idle");

    a_draw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_valid && r_pass2 && (r_act == ACT_PICK)) |->
            ((r_draw != '0) && (r_draw <= r_total)))
        else $error("draw outside 1..total during match scan");

    a_pick_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_res.picked_valid) |-> (r_res.status == ST_OK))
        else $error("picked key reported with a failing status");

endmodule

// File: design/weighted_lottery_selector_core.sv
// Add/remove/update scan the whole table once, then write; a pick scans it once to total the
// positive weights and, if the total is nonzero, draws through a multiply and scans again.
// Clear runs a clearing pass; unused action codes go straight to done. One transaction in
// flight; throughput is set by the table scan. The result sits in an output register, so the
// next transaction is taken while it waits. Reset (i_rst_n low, synchronous) empties the table
// with a clearing pass after release; no transaction is accepted until it finishes.
module weighted_lottery_selector_core #(
    parameter int CAPACITY    = wls_pkg::DEF_CAPACITY,
    parameter int KEY_BITS    = wls_pkg::DEF_KEY_BITS,
    parameter int WEIGHT_BITS = wls_pkg::DEF_WEIGHT_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wls_item_if.sink      i_item,
    wls_result_if.source  o_result
);
    import wls_pkg::*;

    // Item side: the engine takes a transaction only when it has no work running.
    t_request w_req;
    logic     w_eng_idle;
    logic     w_eng_done;
    t_result  w_eng_res;
    logic     w_start;
    logic     w_load;

    // Output register: parts the engine from the downstream handshake.
    logic     r_out_valid;
    t_result  r_out;

    assign w_req = '{action:      i_item.action,
                     move_key:    i_item.move_key,
                     weight:      i_item.weight,
                     random_word: i_item.random_word};

    assign i_item.ready = w_eng_idle;
    assign w_start      = i_item.valid && w_eng_idle;

    wls_engine #(
        .CAPACITY    (CAPACITY),
        .KEY_BITS    (KEY_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_req      (w_req),
        .o_idle     (w_eng_idle),
        .o_done     (w_eng_done),
        .o_res      (w_eng_res),
        .i_res_take (w_load)
    );

    // Finished result moves out when the register is empty or being drained.
    assign w_load = w_eng_done && (!r_out_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) r_out <= w_eng_res;
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out.status;
    assign o_result.picked_key   = r_out.picked_key;
    assign o_result.picked_valid = r_out.picked_valid;

endmodule
